/* src/oled_gddram_controller_defines.svh */
// ----------------------------------------------------------------------------
// OLED GDDRAM controller assertion macros
// Clocked assertion wrappers; empty when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef OLED_GDDRAM_CONTROLLER_DEFINES_SVH
`define OLED_GDDRAM_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define OLEDGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define OLEDGC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLEDGC_ASSERT(label, prop, msg)
`define OLEDGC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/oledgc_pkg.sv */
// ----------------------------------------------------------------------------
// oledgc_pkg
// Shared types and constants of the OLED GDDRAM controller.
// ----------------------------------------------------------------------------
package oledgc_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // host command bytes
  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_DISP_ON   = 8'hAF;
  localparam logic [7:0] CMD_DISP_OFF  = 8'hAE;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_RESET = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic exec;        // input beat accepted, apply it
    logic clear_en;    // write zero at clear counter and advance
    logic load_query;  // RAM read data valid, load query result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_stat_t;

endpackage

/* src/oledgc_ram.sv */
// ----------------------------------------------------------------------------
// oledgc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module oledgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/oledgc_ctrl.sv */
// ----------------------------------------------------------------------------
// oledgc_ctrl
// Control FSM: memory clear sweep, beat acceptance, query read, output valid.
// ----------------------------------------------------------------------------
module oledgc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             opcode,
  output oledgc_pkg::ctrl_cmd_t  cmd,
  input  oledgc_pkg::ctrl_stat_t stat
);

  oledgc_pkg::state_t state, state_next;
  logic               out_valid_next;
  logic               accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oledgc_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oledgc_pkg::ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = oledgc_pkg::ST_IDLE;
        end
      end
      oledgc_pkg::ST_IDLE: begin
        if (accept && opcode == oledgc_pkg::OP_RESET) begin
          state_next = oledgc_pkg::ST_CLEAR;
        end else if (accept && opcode == oledgc_pkg::OP_QUERY) begin
          state_next = oledgc_pkg::ST_READ;
        end
      end
      oledgc_pkg::ST_READ: begin
        state_next = oledgc_pkg::ST_IDLE;
      end
      default: state_next = oledgc_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      oledgc_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      oledgc_pkg::ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        cmd.exec = accept;
      end
      oledgc_pkg::ST_READ: begin
        cmd.load_query = 1'b1;
      end
      default: ;
    endcase

    // output register holds one result beat
    if ((cmd.exec && opcode != oledgc_pkg::OP_QUERY) || cmd.load_query) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* src/oledgc_datapath.sv */
// ----------------------------------------------------------------------------
// oledgc_datapath
// Pointers, window and command registers, display RAM and result register.
// ----------------------------------------------------------------------------
module oledgc_datapath #(
  parameter int COLUMNS = oledgc_pkg::COLUMNS_DEF,
  parameter int PAGES   = oledgc_pkg::PAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  oledgc_pkg::ctrl_cmd_t  cmd,
  output oledgc_pkg::ctrl_stat_t stat,
  input  logic [1:0]             opcode,
  input  logic [7:0]             byte_value,
  input  logic                   is_data,
  input  logic [6:0]             pixel_x,
  input  logic [5:0]             pixel_y,
  output logic                   pixel_on,
  output logic                   display_enabled,
  output logic                   frame_done
);

  localparam int              DEPTH        = COLUMNS * PAGES;
  localparam int              AW           = $clog2(DEPTH);
  localparam logic [7:0]      COL_LIM      = 8'(COLUMNS);
  localparam logic [3:0]      PAGE_LIM     = 4'(PAGES);
  localparam logic [6:0]      COL_END_RST  = 7'(COLUMNS - 1);
  localparam logic [2:0]      PAGE_END_RST = 3'(PAGES - 1);
  localparam logic [AW-1:0]   ADDR_LAST    = AW'(DEPTH - 1);
  localparam logic [AW-1:0]   ROW_STRIDE   = AW'(COLUMNS);

  logic [6:0]    col_ptr, col_ptr_next, col_start, col_start_next, col_end, col_end_next;
  logic [2:0]    page_ptr, page_ptr_next, page_start, page_start_next;
  logic [2:0]    page_end, page_end_next;
  logic [7:0]    pending, pending_next;
  logic [1:0]    params_left, params_left_next;
  logic          disp_flag, disp_flag_next;
  logic [AW-1:0] clear_cnt;
  logic          q_ok;
  logic [2:0]    q_bit;

  logic          frame_nx, wr_en, wr_ok, rd_ok, is_query, is_reset;
  logic [1:0]    params_dec;
  logic [AW-1:0] wr_addr, rd_addr, ram_addr;
  logic [7:0]    ram_rdata;

  assign is_query = cmd.exec && opcode == oledgc_pkg::OP_QUERY;
  assign is_reset = cmd.exec && opcode == oledgc_pkg::OP_RESET;
  assign wr_ok    = ({1'b0, col_ptr} < COL_LIM) && ({1'b0, page_ptr} < PAGE_LIM);
  assign rd_ok    = ({1'b0, pixel_x} < COL_LIM) && ({1'b0, pixel_y[5:3]} < PAGE_LIM);
  assign wr_addr  = AW'(page_ptr) * ROW_STRIDE + AW'(col_ptr);
  assign rd_addr  = AW'(pixel_y[5:3]) * ROW_STRIDE + AW'(pixel_x);
  assign params_dec = params_left - 2'd1;
  assign stat.clear_last = clear_cnt == ADDR_LAST;

  always_comb begin
    col_ptr_next     = col_ptr;
    col_start_next   = col_start;
    col_end_next     = col_end;
    page_ptr_next    = page_ptr;
    page_start_next  = page_start;
    page_end_next    = page_end;
    pending_next     = pending;
    params_left_next = params_left;
    disp_flag_next   = disp_flag;
    frame_nx         = 1'b0;
    wr_en            = 1'b0;
    if (cmd.exec) begin
      unique case (opcode)
        oledgc_pkg::OP_BYTE: begin
          if (is_data) begin
            wr_en = wr_ok;
            if (col_ptr == col_end) begin
              col_ptr_next  = col_start;
              page_ptr_next = (page_ptr == page_end) ? page_start : page_ptr + 3'd1;
              frame_nx      = page_ptr_next == page_start;
            end else begin
              col_ptr_next = col_ptr + 7'd1;
            end
          end else if (params_left != 2'd0) begin
            // parameter byte of a pending window command
            params_left_next = params_dec;
            if (pending == oledgc_pkg::CMD_COL_ADDR) begin
              if (params_dec == 2'd1) begin
                col_start_next = byte_value[6:0];
                col_ptr_next   = byte_value[6:0];
              end else begin
                col_end_next = byte_value[6:0];
              end
            end else if (pending == oledgc_pkg::CMD_PAGE_ADDR) begin
              if (params_dec == 2'd1) begin
                page_start_next = byte_value[2:0];
                page_ptr_next   = byte_value[2:0];
              end else begin
                page_end_next = byte_value[2:0];
              end
            end
          end else begin
            pending_next = byte_value;
            if (byte_value == oledgc_pkg::CMD_COL_ADDR ||
                byte_value == oledgc_pkg::CMD_PAGE_ADDR) begin
              params_left_next = 2'd2;
            end else if (byte_value == oledgc_pkg::CMD_DISP_ON) begin
              disp_flag_next = 1'b1;
            end else if (byte_value == oledgc_pkg::CMD_DISP_OFF) begin
              disp_flag_next = 1'b0;
            end
          end
        end
        oledgc_pkg::OP_RESET: begin
          col_ptr_next     = '0;
          col_start_next   = '0;
          col_end_next     = COL_END_RST;
          page_ptr_next    = '0;
          page_start_next  = '0;
          page_end_next    = PAGE_END_RST;
          pending_next     = '0;
          params_left_next = '0;
          disp_flag_next   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_ptr     <= '0;
      col_start   <= '0;
      col_end     <= COL_END_RST;
      page_ptr    <= '0;
      page_start  <= '0;
      page_end    <= PAGE_END_RST;
      pending     <= '0;
      params_left <= '0;
      disp_flag   <= 1'b0;
      clear_cnt   <= '0;
    end else begin
      col_ptr     <= col_ptr_next;
      col_start   <= col_start_next;
      col_end     <= col_end_next;
      page_ptr    <= page_ptr_next;
      page_start  <= page_start_next;
      page_end    <= page_end_next;
      pending     <= pending_next;
      params_left <= params_left_next;
      disp_flag   <= disp_flag_next;
      if (is_reset || (cmd.clear_en && stat.clear_last)) begin
        clear_cnt <= '0;
      end else if (cmd.clear_en) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
    end
  end

  // result register and query sideband
  always_ff @(posedge clk) begin
    if (is_query) begin
      q_ok  <= rd_ok;
      q_bit <= pixel_y[2:0];
    end
    if (cmd.load_query) begin
      pixel_on        <= q_ok && disp_flag && ram_rdata[q_bit];
      display_enabled <= disp_flag;
      frame_done      <= 1'b0;
    end else if (cmd.exec && !is_query) begin
      pixel_on        <= 1'b0;
      display_enabled <= disp_flag_next;
      frame_done      <= frame_nx;
    end
  end

  always_comb begin
    if (cmd.clear_en) begin
      ram_addr = clear_cnt;
    end else if (is_query) begin
      ram_addr = rd_addr;
    end else begin
      ram_addr = wr_addr;
    end
  end

  oledgc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clear_en || wr_en),
    .addr  (ram_addr),
    .wdata (cmd.clear_en ? 8'h00 : byte_value),
    .rdata (ram_rdata)
  );

endmodule

/* src/oled_gddram_controller.sv */
// ----------------------------------------------------------------------------
// oled_gddram_controller
// Monochrome OLED controller: page-organized display RAM, horizontal addressing.
// ----------------------------------------------------------------------------
// Host bytes and unused opcodes give a registered result beat that shows the
// cycle after acceptance. A pixel query's result passes the registered display
// RAM read and then the result register. After rst and after a panel reset
// beat the controller sweeps all COLUMNS*PAGES entries (1024 with defaults) of
// the display RAM to zero, one entry per cycle, and accepts no input during
// the sweep; the reset beat's own result is still delivered. An input beat is
// taken in idle once the result register is empty or being emptied in that cycle.
`include "oled_gddram_controller_defines.svh"

module oled_gddram_controller #(
  parameter int COLUMNS = oledgc_pkg::COLUMNS_DEF,
  parameter int PAGES   = oledgc_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] byte_value,
  input  logic       is_data,
  input  logic [6:0] pixel_x,
  input  logic [5:0] pixel_y,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       pixel_on,
  output logic       display_enabled,
  output logic       frame_done
);

  oledgc_pkg::ctrl_cmd_t  cmd;
  oledgc_pkg::ctrl_stat_t stat;

  oledgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .opcode    (opcode),
    .cmd       (cmd),
    .stat      (stat)
  );

  oledgc_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (opcode),
    .byte_value      (byte_value),
    .is_data         (is_data),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .pixel_on        (pixel_on),
    .display_enabled (display_enabled),
    .frame_done      (frame_done)
  );

  `OLEDGC_ASSERT_ALWAYS(a_no_accept_after_rst, rst |=> !in_ready, "input taken during clear")
  `OLEDGC_ASSERT(a_query_two_cycles, (in_valid && in_ready && opcode == oledgc_pkg::OP_QUERY) |=> ##1 out_valid, "query result late")
  `OLEDGC_ASSERT(a_reset_result, (in_valid && in_ready && opcode == oledgc_pkg::OP_RESET) |=> (out_valid && !display_enabled && !pixel_on && !in_ready), "panel reset result wrong")
  `OLEDGC_ASSERT(a_frame_not_query, (out_valid && frame_done) |-> !pixel_on, "frame_done on query beat")

endmodule
